// File: hw/rtl/sec2date_pkg.sv
`default_nettype none

package sec2date_pkg;

    // Width of the biased second count, which is always non-negative.
    localparam int DIV_W = 33;
    localparam int QUO_W = 16;
    localparam int DAY_W = 16;
    localparam int C400_W = 9;

    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN = 60;
    localparam int DAYS_PER_WEEK = 7;

    // Bias of a whole number of days that makes every input count non-negative.
    localparam int DAY_OFFSET = 24856;
    localparam logic [DIV_W-1:0] SEC_OFFSET = DIV_W'(DAY_OFFSET * 64'(SECS_PER_DAY));
    // (biased day + WEEK_BIAS) mod 7 gives 0 for Monday.
    localparam int WEEK_BIAS = 6;

    localparam int EPOCH_YEAR = 2000;
    localparam int YEAR_MIN = 1931;
    localparam int YEAR_MAX = 2068;
    localparam logic [C400_W-1:0] C400_LAST = C400_W'(399);

    // A day is 675 * 128 seconds, so the low seven bits bypass the day division.
    localparam int SEC_LO_W = 7;
    localparam int DAY_REM_W = 10;
    localparam int DIVX_W = DIV_W - SEC_LO_W;

    // Division by a constant: a quotient estimate from a reciprocal rounded down is at most
    // one short for any dividend below 2**RECIP_SHIFT, so one correction step completes it.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W = 24;
    localparam int PROD_W = RECIP_SHIFT + QUO_W;
    localparam int DVS_W = 12;
    localparam int REM_W = 13;

    localparam logic [DVS_W-1:0] DAY_DVS = DVS_W'(SECS_PER_DAY >> SEC_LO_W);
    localparam logic [DVS_W-1:0] HOUR_DVS = DVS_W'(SECS_PER_HOUR);
    localparam logic [DVS_W-1:0] MIN_DVS = DVS_W'(SECS_PER_MIN);
    localparam logic [DVS_W-1:0] WD_DVS = DVS_W'(DAYS_PER_WEEK);

    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SECS_PER_DAY >> SEC_LO_W));
    localparam logic [RECIP_W-1:0] HOUR_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SECS_PER_HOUR));
    localparam logic [RECIP_W-1:0] MIN_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SECS_PER_MIN));
    localparam logic [RECIP_W-1:0] WD_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DAYS_PER_WEEK));

    // Phases of one division, counted down.
    typedef logic [1:0] step_cnt_t;
    localparam step_cnt_t DIV_PH_MUL = 2'd2;
    localparam step_cnt_t DIV_PH_SUB = 2'd1;
    localparam step_cnt_t DIV_PH_FIX = 2'd0;

    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_MUL,
        OP_DIV_SUB,
        OP_DIV_FIX,
        OP_HOUR_START,
        OP_MIN_START,
        OP_WD_START,
        OP_YEAR_START,
        OP_YEAR_STEP,
        OP_MONTH_STEP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY_DIV,
        S_HOUR_INIT,
        S_HOUR_DIV,
        S_MIN_INIT,
        S_MIN_DIV,
        S_WD_INIT,
        S_WD_DIV,
        S_YEAR_INIT,
        S_YEAR,
        S_MONTH,
        S_DONE
    } state_t;

    // Leap rule from the year modulo 400.
    function automatic logic is_leap(input logic [C400_W-1:0] c);
        return (c[1:0] == 2'd0) &&
               !(c == C400_W'(100) || c == C400_W'(200) || c == C400_W'(300));
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = (m > MONTH_DEC) ? 5'd0 : MONTH_LEN[m];
        if (m == MONTH_FEB && leap)
        begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sec2date_dp.sv
`default_nettype none

module sec2date_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sec2date_pkg::cmd_t    cmd,
    output sec2date_pkg::status_t      status,
    input  wire logic [31:0]           seconds_since_epoch,
    output logic [5:0]                 second_of_minute,
    output logic [5:0]                 minute_of_hour,
    output logic [4:0]                 hour_of_day,
    output logic [4:0]                 day_of_month,
    output logic [3:0]                 month_of_year,
    output logic [11:0]                year_number,
    output logic [2:0]                 weekday
);
    import sec2date_pkg::*;

    logic [DIVX_W-1:0]   x_reg, x_next;
    logic [SEC_LO_W-1:0] lo_reg, lo_next;
    logic [RECIP_W-1:0]  recip_reg, recip_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic [REM_W-1:0]    r_reg, r_next;
    logic [DAY_W-1:0]    days_reg, days_next;
    logic [DAY_W-1:0]    d_reg, d_next;
    logic [11:0]         year_reg, year_next;
    logic [C400_W-1:0]   c400_reg, c400_next;
    logic [3:0]          month_reg, month_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          min_reg, min_next;
    logic [5:0]          sec_reg, sec_next;
    logic [2:0]          wd_reg, wd_next;

    logic [5:0]  out_sec_reg, out_min_reg;
    logic [4:0]  out_hour_reg, out_dom_reg;
    logic [3:0]  out_month_reg;
    logic [11:0] out_year_reg;
    logic [2:0]  out_wd_reg;

    logic [C400_W-1:0] c400_prev;
    logic              leap_cur;
    logic [8:0]        ylen_cur, ylen_prev;
    logic [4:0]        mdays;
    logic              d_neg;
    logic [DIV_W-1:0]  biased;
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  back;

    always_comb
    begin
        c400_prev = (c400_reg == '0) ? C400_LAST : c400_reg - C400_W'(1);
        leap_cur  = is_leap(c400_reg);
        ylen_cur  = year_len(leap_cur);
        ylen_prev = year_len(is_leap(c400_prev));
        mdays     = month_days(month_reg, leap_cur);
        d_neg     = d_reg[DAY_W-1];
        biased    = {seconds_since_epoch[31], seconds_since_epoch} + SEC_OFFSET;
        prod      = PROD_W'(x_reg) * PROD_W'(recip_reg);
        // Only the low bits of the multiply-back matter, as the remainder is below twice
        // the divisor.
        back      = REM_W'(q_reg) * REM_W'(dvs_reg);

        status.year_done  = !d_neg && (d_reg < DAY_W'(ylen_cur));
        status.month_done = (month_reg > MONTH_DEC) || (DAY_W'(mdays) > d_reg);
    end

    always_comb
    begin
        x_next     = x_reg;
        lo_next    = lo_reg;
        recip_next = recip_reg;
        dvs_next   = dvs_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        days_next  = days_reg;
        d_next     = d_reg;
        year_next  = year_reg;
        c400_next  = c400_reg;
        month_next = month_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        wd_next    = wd_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                x_next     = biased[DIV_W-1:SEC_LO_W];
                lo_next    = biased[SEC_LO_W-1:0];
                recip_next = DAY_RECIP;
                dvs_next   = DAY_DVS;
            end
            OP_DIV_MUL:
            begin
                q_next = prod[PROD_W-1:RECIP_SHIFT];
            end
            OP_DIV_SUB:
            begin
                r_next = REM_W'(x_reg) - back;
            end
            OP_DIV_FIX:
            begin
                if (r_reg >= REM_W'(dvs_reg))
                begin
                    r_next = r_reg - REM_W'(dvs_reg);
                    q_next = q_reg + QUO_W'(1);
                end
            end
            OP_HOUR_START:
            begin
                // The day remainder and the bypassed low bits form the second of the day.
                days_next  = q_reg;
                x_next     = DIVX_W'({r_reg[DAY_REM_W-1:0], lo_reg});
                recip_next = HOUR_RECIP;
                dvs_next   = HOUR_DVS;
            end
            OP_MIN_START:
            begin
                hour_next  = q_reg[4:0];
                x_next     = DIVX_W'(r_reg);
                recip_next = MIN_RECIP;
                dvs_next   = MIN_DVS;
            end
            OP_WD_START:
            begin
                min_next   = q_reg[5:0];
                sec_next   = r_reg[5:0];
                x_next     = DIVX_W'(days_reg) + DIVX_W'(WEEK_BIAS);
                recip_next = WD_RECIP;
                dvs_next   = WD_DVS;
            end
            OP_YEAR_START:
            begin
                wd_next    = r_reg[2:0] + 3'd1;
                d_next     = days_reg - DAY_W'(DAY_OFFSET);
                year_next  = 12'(EPOCH_YEAR);
                c400_next  = '0;
                month_next = 4'd1;
            end
            OP_YEAR_STEP:
            begin
                if (d_neg)
                begin
                    d_next    = d_reg + DAY_W'(ylen_prev);
                    year_next = year_reg - 12'd1;
                    c400_next = c400_prev;
                end
                else if (!status.year_done)
                begin
                    d_next    = d_reg - DAY_W'(ylen_cur);
                    year_next = year_reg + 12'd1;
                    c400_next = (c400_reg == C400_LAST) ? '0 : c400_reg + C400_W'(1);
                end
            end
            OP_MONTH_STEP:
            begin
                if (!status.month_done)
                begin
                    d_next     = d_reg - DAY_W'(mdays);
                    month_next = month_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lo_reg    <= lo_next;
        recip_reg <= recip_next;
        dvs_reg   <= dvs_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        days_reg  <= days_next;
        d_reg     <= d_next;
        year_reg  <= year_next;
        c400_reg  <= c400_next;
        month_reg <= month_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        wd_reg    <= wd_next;
        if (cmd.out_load)
        begin
            out_sec_reg   <= sec_reg;
            out_min_reg   <= min_reg;
            out_hour_reg  <= hour_reg;
            out_dom_reg   <= d_reg[4:0] + 5'd1;
            out_month_reg <= month_reg;
            out_year_reg  <= year_reg;
            out_wd_reg    <= wd_reg;
        end
    end

    assign second_of_minute = out_sec_reg;
    assign minute_of_hour   = out_min_reg;
    assign hour_of_day      = out_hour_reg;
    assign day_of_month     = out_dom_reg;
    assign month_of_year    = out_month_reg;
    assign year_number      = out_year_reg;
    assign weekday          = out_wd_reg;

    // The month walk starts only once the year walk has left a non-negative day.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MONTH_STEP) |-> !d_reg[DAY_W-1])
        else $error("month walk with negative day count");

    // The modulo-400 tracker must stay in step with the year.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_YEAR_STEP) |-> (c400_reg[1:0] == year_reg[1:0]))
        else $error("leap tracker out of step with year");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (year_reg >= 12'(YEAR_MIN) && year_reg <= 12'(YEAR_MAX) &&
                          month_reg >= 4'd1 && month_reg <= MONTH_DEC))
        else $error("date out of range at result load");

endmodule

`default_nettype wire

// File: hw/rtl/sec2date_ctrl.sv
`default_nettype none

module sec2date_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output sec2date_pkg::cmd_t          cmd,
    input  wire sec2date_pkg::status_t  status
);
    import sec2date_pkg::*;

    state_t    state_reg, state_next;
    step_cnt_t cnt_reg, cnt_next;
    logic      out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = DIV_PH_MUL;
                    state_next = S_DAY_DIV;
                end
            end
            S_DAY_DIV, S_HOUR_DIV, S_MIN_DIV, S_WD_DIV:
            begin
                if (cnt_reg == DIV_PH_MUL)
                begin
                    cmd.op = OP_DIV_MUL;
                end
                else if (cnt_reg == DIV_PH_SUB)
                begin
                    cmd.op = OP_DIV_SUB;
                end
                else
                begin
                    cmd.op = OP_DIV_FIX;
                end
                cnt_next = cnt_reg - step_cnt_t'(1);
                if (cnt_reg == DIV_PH_FIX)
                begin
                    unique case (state_reg)
                        S_DAY_DIV:  state_next = S_HOUR_INIT;
                        S_HOUR_DIV: state_next = S_MIN_INIT;
                        S_MIN_DIV:  state_next = S_WD_INIT;
                        default:    state_next = S_YEAR_INIT;
                    endcase
                end
            end
            S_HOUR_INIT:
            begin
                cmd.op     = OP_HOUR_START;
                cnt_next   = DIV_PH_MUL;
                state_next = S_HOUR_DIV;
            end
            S_MIN_INIT:
            begin
                cmd.op     = OP_MIN_START;
                cnt_next   = DIV_PH_MUL;
                state_next = S_MIN_DIV;
            end
            S_WD_INIT:
            begin
                cmd.op     = OP_WD_START;
                cnt_next   = DIV_PH_MUL;
                state_next = S_WD_DIV;
            end
            S_YEAR_INIT:
            begin
                cmd.op     = OP_YEAR_START;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (status.year_done)
                begin
                    state_next = S_MONTH;
                end
                else
                begin
                    cmd.op = OP_YEAR_STEP;
                end
            end
            S_MONTH:
            begin
                if (status.month_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_MONTH_STEP;
                end
            end
            S_DONE:
            begin
                // The result register may be refilled in the cycle its transaction completes.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before its transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> $past(cmd.out_load))
        else $error("returned to idle without loading a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("left the done state while the result was stalled");

endmodule

`default_nettype wire

// File: hw/rtl/seconds_to_calendar_date_time.sv
// Converts a signed count of seconds from 2000-01-01 00:00:00 into time of day, Gregorian
// date and day of week (1 Monday to 7 Sunday), one transaction at a time. A conversion
// makes four passes through one shared constant divider (days, hours, minutes and day of
// week), each a reciprocal multiplication, a multiply-back with subtraction and one
// correction step; it then walks one whole year at a time from 2000 to the target year and
// one whole month at a time, with set-up and hand-over steps between. The result sits in an
// output register, so a new input is taken while an earlier result waits to be collected.
`default_nettype none

module seconds_to_calendar_date_time (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] seconds_since_epoch,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       second_of_minute,
    output logic [5:0]       minute_of_hour,
    output logic [4:0]       hour_of_day,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_of_year,
    output logic [11:0]      year_number,
    output logic [2:0]       weekday
);
    import sec2date_pkg::*;

    cmd_t    cmd;
    status_t status;

    sec2date_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    sec2date_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .seconds_since_epoch (seconds_since_epoch),
        .second_of_minute    (second_of_minute),
        .minute_of_hour      (minute_of_hour),
        .hour_of_day         (hour_of_day),
        .day_of_month        (day_of_month),
        .month_of_year       (month_of_year),
        .year_number         (year_number),
        .weekday             (weekday)
    );

endmodule

`default_nettype wire

// File: bench/tb_seconds_to_calendar_date_time.sv
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date_time;

    localparam int DAY_SECONDS = 86400;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  wday;
    } date_time_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic        settle_first;
    } timestamp_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] seconds_since_epoch = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [11:0] year_number;
    logic [2:0]  weekday;

    timestamp_item_t timestamps_to_send[$];
    date_time_t      predicted_dates[$];

    int error_count = 0;
    int total_items = 0;
    int sent_count = 0;
    int negative_count = 0;
    int checked_count = 0;
    int earliest_year = 4095;
    int latest_year = 0;
    int gap_left = 0;
    int in_calm = 0;
    int stall_left = 0;
    int out_calm = 0;

    seconds_to_calendar_date_time uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .seconds_since_epoch (seconds_since_epoch),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .second_of_minute    (second_of_minute),
        .minute_of_hour      (minute_of_hour),
        .hour_of_day         (hour_of_day),
        .day_of_month        (day_of_month),
        .month_of_year       (month_of_year),
        .year_number         (year_number),
        .weekday             (weekday)
    );

    always #5 clk = ~clk;

    function automatic bit is_leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_year(input int y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int days_in_month(input int m, input int y);
        case (m)
            2: return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // Whole days are floored, so the time of day never goes negative.
    function automatic date_time_t convert_timestamp(input logic [31:0] stamp);
        longint     total;
        longint     days;
        longint     tod;
        longint     wd;
        int         yr;
        int         mo;
        int         d;
        date_time_t r;
        total = $signed(stamp);
        days = total / DAY_SECONDS;
        tod = total % DAY_SECONDS;
        if (tod < 0)
        begin
            tod += DAY_SECONDS;
            days -= 1;
        end
        r.hour = 5'(tod / 3600);
        r.minute = 6'((tod % 3600) / 60);
        r.second = 6'(tod % 60);
        wd = days % 7;
        if (wd < 0)
        begin
            wd += 7;
        end
        // Day zero is a Saturday, which is 6 on a Monday-based count.
        r.wday = 3'((wd + 5) % 7 + 1);
        yr = 2000;
        d = int'(days);
        while (d >= days_in_year(yr))
        begin
            d -= days_in_year(yr);
            yr++;
        end
        while (d < 0)
        begin
            yr--;
            d += days_in_year(yr);
        end
        mo = 1;
        while (mo < 12 && d >= days_in_month(mo, yr))
        begin
            d -= days_in_month(mo, yr);
            mo++;
        end
        r.mday = 5'(d + 1);
        r.month = 4'(mo);
        r.year = 12'(yr);
        return r;
    endfunction

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            return $urandom_range(1, 2);
        end
        if (pick < 90)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 120);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      checked_count, name, got, want));
        end
    endtask

    task automatic add_timestamp(input logic [31:0] stamp, input bit settle);
        timestamp_item_t item;
        item.stamp = stamp;
        item.settle_first = settle;
        timestamps_to_send.push_back(item);
    endtask

    always @(posedge clk)
    begin : driver
        timestamp_item_t item;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted_dates.push_back(convert_timestamp(seconds_since_epoch));
                sent_count++;
                if ($signed(seconds_since_epoch) < 0)
                begin
                    negative_count++;
                end
                gap_left = (in_calm > 0 || $urandom_range(0, 1) == 0) ? 0 : idle_length();
                if (in_calm > 0)
                begin
                    in_calm--;
                end
                else if ($urandom_range(0, 24) == 0)
                begin
                    in_calm = 40;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (timestamps_to_send.size() > 0 &&
                         !(timestamps_to_send[0].settle_first && predicted_dates.size() > 0))
                begin
                    item = timestamps_to_send.pop_front();
                    in_valid <= 1'b1;
                    seconds_since_epoch <= item.stamp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        date_time_t seen;
        date_time_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {second_of_minute, minute_of_hour, hour_of_day, day_of_month,
                        month_of_year, year_number, weekday};
                if (predicted_dates.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                                              seen.year, seen.month, seen.mday,
                                              seen.hour, seen.minute, seen.second));
                end
                else
                begin
                    want = predicted_dates.pop_front();
                    check_field("second_of_minute", seen.second, want.second);
                    check_field("minute_of_hour", seen.minute, want.minute);
                    check_field("hour_of_day", seen.hour, want.hour);
                    check_field("day_of_month", seen.mday, want.mday);
                    check_field("month_of_year", seen.month, want.month);
                    check_field("year_number", seen.year, want.year);
                    check_field("weekday", seen.wday, want.wday);
                    checked_count++;
                    if (want.year < earliest_year)
                    begin
                        earliest_year = want.year;
                    end
                    if (want.year > latest_year)
                    begin
                        latest_year = want.year;
                    end
                end
            end
            // Stalls are drawn per cycle, so they land on every phase of a conversion.
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (out_calm == 0 && $urandom_range(0, 11) == 0)
            begin
                stall_left = idle_length() - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            if (out_calm > 0)
            begin
                out_calm--;
            end
            else if ($urandom_range(0, 499) == 0)
            begin
                out_calm = 400;
            end
        end
    end

    initial
    begin
        int     kind;
        int     y;
        int     m;
        int     dd;
        longint days;
        longint tod;

        // Extremes of the input, minute, hour and day edges either side of the epoch.
        add_timestamp(32'd0, 1'b0);
        add_timestamp(-1, 1'b0);
        add_timestamp(32'h7FFF_FFFF, 1'b0);
        add_timestamp(32'h8000_0000, 1'b0);
        add_timestamp(59, 1'b0);
        add_timestamp(60, 1'b0);
        add_timestamp(3599, 1'b0);
        add_timestamp(3600, 1'b0);
        add_timestamp(DAY_SECONDS - 1, 1'b0);
        add_timestamp(DAY_SECONDS, 1'b0);
        add_timestamp(-DAY_SECONDS, 1'b0);
        add_timestamp(-DAY_SECONDS - 1, 1'b0);
        // Leap days, the turn of a leap year and the turn of the previous year.
        add_timestamp(59 * DAY_SECONDS, 1'b0);
        add_timestamp(60 * DAY_SECONDS - 1, 1'b0);
        add_timestamp(60 * DAY_SECONDS, 1'b0);
        add_timestamp(366 * DAY_SECONDS - 1, 1'b0);
        add_timestamp(366 * DAY_SECONDS, 1'b0);
        add_timestamp(1520 * DAY_SECONDS, 1'b0);
        add_timestamp(-1402 * DAY_SECONDS, 1'b0);
        add_timestamp(-365 * DAY_SECONDS, 1'b0);
        add_timestamp(-365 * DAY_SECONDS - 1, 1'b0);
        add_timestamp(32'h5555_5555, 1'b0);
        add_timestamp(32'hAAAA_AAAA, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                days = 0;
                tod = $urandom();
                add_timestamp(32'(tod), i == 0 || i == RANDOM_ITEMS / 2);
            end
            else
            begin
                if (kind < 7)
                begin
                    // First or last day of a month in the years 1932 to 2037.
                    y = $urandom_range(1932, 2037);
                    m = $urandom_range(1, 12);
                    dd = $urandom_range(0, 1) ? days_in_month(m, y) : 1;
                end
                else
                begin
                    y = $urandom_range(1996, 2004);
                    m = $urandom_range(1, 12);
                    dd = $urandom_range(1, days_in_month(m, y));
                end
                days = 0;
                for (int yy = 2000; yy < y; yy++)
                begin
                    days += days_in_year(yy);
                end
                for (int yy = y; yy < 2000; yy++)
                begin
                    days -= days_in_year(yy);
                end
                for (int mm = 1; mm < m; mm++)
                begin
                    days += days_in_month(mm, y);
                end
                days += dd - 1;
                case ($urandom_range(0, 2))
                    0: tod = 0;
                    1: tod = DAY_SECONDS - 1;
                    default: tod = $urandom_range(0, DAY_SECONDS - 1);
                endcase
                add_timestamp(32'(days * DAY_SECONDS + tod), i == 0 || i == RANDOM_ITEMS / 2);
            end
        end
        total_items = timestamps_to_send.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_items || predicted_dates.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d timestamps (%0d before the epoch); %0d results checked.",
                 sent_count, negative_count, checked_count);
        $display("Dates seen ran from year %0d to %0d, with stalls on both handshakes.",
                 earliest_year, latest_year);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Timeout with %0d of %0d transactions sent and %0d results outstanding.",
                 sent_count, total_items, predicted_dates.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/sec2date_pkg.sv
hw/rtl/sec2date_dp.sv
hw/rtl/sec2date_ctrl.sv
hw/rtl/seconds_to_calendar_date_time.sv
bench/tb_seconds_to_calendar_date_time.sv
